@@ rtl/core/rpa_pkg.sv @@
// shared types, widths and codes of the refcounted page allocator
// no dependencies; used by rpa_ctrl, rpa_datapath and the top level
`timescale 1ns / 1ps

package rpa_pkg;

  localparam int ADDR_W      = 24;
  localparam int CFG_W       = 13;
  localparam int CFG_IDX_W   = 1;
  localparam int OPC_W       = 2;
  localparam int STS_W       = 3;
  localparam int CNT_OUT_W   = 8;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 40;

  localparam int NUM_PAGES_DEF  = 4096;
  localparam int PAGE_SHIFT_DEF = 12;
  localparam int COUNT_BITS_DEF = 8;

  localparam logic [CFG_W-1:0] FIRST_PAGE_RST = 13'd0;
  localparam logic [CFG_W-1:0] LIMIT_PAGE_RST = 13'd4096;

  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_PAGE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_PAGE = 1'b1;

  typedef enum logic [OPC_W-1:0] {
    OP_INIT   = 2'd0,
    OP_ALLOC  = 2'd1,
    OP_FREE   = 2'd2,
    OP_INCREF = 2'd3
  } op_t;

  typedef enum logic [STS_W-1:0] {
    STS_OK        = 3'd0,
    STS_EMPTY     = 3'd1,
    STS_BAD_ADDR  = 3'd2,
    STS_BAD_COUNT = 3'd3,
    STS_SATURATED = 3'd4
  } sts_t;

  // controller to datapath
  typedef struct packed {
    logic take;
    logic depth_clr;
    logic sweep;
    logic sweep_push;
    logic stk_rd;
    logic cnt_rd;
    logic exec;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic sweep_last;
    logic out_hold;
  } dp_sts_t;

endpackage

@@ rtl/core/rpa_ctrl.sv @@
// sequencing state machine of the refcounted page allocator
// depends on rpa_pkg; drives rpa_datapath through dp_cmd_t
`timescale 1ns / 1ps

module rpa_ctrl
  import rpa_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [OPC_W-1:0] in_opcode,
  output dp_cmd_t          cmd,
  input  dp_sts_t          sts
);

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_INIT  = 6'b000100,
    ST_STK   = 6'b001000,
    ST_CNT   = 6'b010000,
    ST_EXEC  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   take;
  op_t    op_in;

  assign op_in     = op_t'(in_opcode);
  assign in_tready = (state_r == ST_IDLE);
  assign take      = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        cmd.take = take;
        if (take) begin
          unique case (op_in)
            OP_INIT: begin
              cmd.depth_clr = 1'b1;
              state_nxt     = ST_INIT;
            end
            OP_ALLOC: state_nxt = ST_STK;
            OP_FREE, OP_INCREF: state_nxt = ST_CNT;
            default: state_nxt = ST_CNT;
          endcase
        end
      end
      ST_INIT: begin
        cmd.sweep      = 1'b1;
        cmd.sweep_push = 1'b1;
        if (sts.sweep_last) state_nxt = ST_EXEC;
      end
      ST_STK: begin
        cmd.stk_rd = 1'b1;
        state_nxt  = ST_CNT;
      end
      ST_CNT: begin
        cmd.cnt_rd = 1'b1;
        state_nxt  = ST_EXEC;
      end
      ST_EXEC: begin
        cmd.exec = !sts.out_hold;
        if (!sts.out_hold) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ rtl/core/rpa_datapath.sv @@
// count memory, free stack, config registers and result register
// depends on rpa_pkg; commanded by rpa_ctrl
`timescale 1ns / 1ps

module rpa_datapath
  import rpa_pkg::*;
#(
  parameter int NUM_PAGES  = NUM_PAGES_DEF,
  parameter int PAGE_SHIFT = PAGE_SHIFT_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  dp_cmd_t                cmd,
  output dp_sts_t                sts,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  input  logic [OPC_W-1:0]       in_opcode,
  input  logic [ADDR_W-1:0]      in_page_address,
  input  logic                   out_tready,
  output logic                   out_tvalid,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int PAGE_W  = $clog2(NUM_PAGES);
  localparam int DEPTH_W = $clog2(NUM_PAGES + 1);
  localparam int PFLD_W  = ADDR_W - PAGE_SHIFT;
  localparam int CMP_A   = (PFLD_W > DEPTH_W) ? PFLD_W : DEPTH_W;
  localparam int CMP_W   = (CMP_A > CFG_W) ? CMP_A : CFG_W;
  localparam int PAD_W   = OUT_TDATA_W - STS_W - ADDR_W - CNT_OUT_W;

  logic [COUNT_BITS-1:0] cnt_mem [NUM_PAGES];
  logic [PAGE_W-1:0]     stk_mem [NUM_PAGES];

  logic [CFG_W-1:0]       first_r, limit_r;
  logic [DEPTH_W-1:0]     depth_r, depth_nxt;
  logic [PAGE_W-1:0]      swp_r;
  op_t                    op_r;
  logic                   addr_ok_r;
  logic [PAGE_W-1:0]      page_r;
  logic [PAGE_W-1:0]      stk_q;
  logic [COUNT_BITS-1:0]  cnt_q;
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  logic [PFLD_W-1:0]     in_pfld;
  logic                  in_addr_ok;
  logic [CMP_W-1:0]      top_pg;
  logic                  swp_in_rng;
  logic [DEPTH_W-1:0]    depth_m1;
  logic [PAGE_W-1:0]     stk_ra;
  logic [PAGE_W-1:0]     cnt_ra;
  logic                  depth_full;

  sts_t                  ex_sts;
  logic [ADDR_W-1:0]     ex_addr;
  logic [COUNT_BITS-1:0] ex_cnt;
  logic                  ex_we, ex_pop, ex_push;
  logic [PAGE_W-1:0]     ex_wa;
  logic [COUNT_BITS-1:0] ex_wd, cnt_dec, cnt_inc;

  logic                  cnt_we;
  logic [PAGE_W-1:0]     cnt_wa;
  logic [COUNT_BITS-1:0] cnt_wd;
  logic                  stk_we;
  logic [PAGE_W-1:0]     stk_wd;

  // address check on the incoming beat
  assign in_pfld    = in_page_address[ADDR_W-1:PAGE_SHIFT];
  assign in_addr_ok = (in_page_address[PAGE_SHIFT-1:0] == '0)
                   && (CMP_W'(in_pfld) >= CMP_W'(first_r))
                   && (CMP_W'(in_pfld) <  CMP_W'(limit_r))
                   && (CMP_W'(in_pfld) <  CMP_W'(NUM_PAGES));

  // init sweep range
  assign top_pg     = (CMP_W'(limit_r) < CMP_W'(NUM_PAGES)) ? CMP_W'(limit_r)
                                                             : CMP_W'(NUM_PAGES);
  assign swp_in_rng = (CMP_W'(swp_r) >= CMP_W'(first_r)) && (CMP_W'(swp_r) < top_pg);

  assign depth_m1   = depth_r - DEPTH_W'(1);
  assign stk_ra     = (depth_r == '0) ? '0 : depth_m1[PAGE_W-1:0];
  assign cnt_ra     = (op_r == OP_ALLOC) ? stk_q : page_r;
  assign depth_full = (depth_r >= DEPTH_W'(NUM_PAGES));
  assign cnt_dec    = cnt_q - COUNT_BITS'(1);
  assign cnt_inc    = cnt_q + COUNT_BITS'(1);

  assign sts.sweep_last = (swp_r == PAGE_W'(NUM_PAGES - 1));
  assign sts.out_hold   = out_valid_r && !out_tready;

  // operation outcome from the fetched count
  always_comb begin
    ex_sts  = STS_OK;
    ex_addr = '0;
    ex_cnt  = '0;
    ex_we   = 1'b0;
    ex_pop  = 1'b0;
    ex_push = 1'b0;
    ex_wa   = page_r;
    ex_wd   = '0;
    unique case (op_r)
      OP_INIT: begin
        ex_sts = STS_OK;
      end
      OP_ALLOC: begin
        if (depth_r == '0) begin
          ex_sts = STS_EMPTY;
        end else if (cnt_q != '0) begin
          ex_sts = STS_BAD_COUNT;
          ex_cnt = cnt_q;
        end else begin
          ex_pop  = 1'b1;
          ex_we   = 1'b1;
          ex_wa   = stk_q;
          ex_wd   = COUNT_BITS'(1);
          ex_addr = ADDR_W'({stk_q, {PAGE_SHIFT{1'b0}}});
          ex_cnt  = COUNT_BITS'(1);
        end
      end
      OP_FREE: begin
        if (!addr_ok_r) begin
          ex_sts = STS_BAD_ADDR;
        end else if (cnt_q == '0) begin
          ex_sts = STS_BAD_COUNT;
        end else begin
          ex_we   = 1'b1;
          ex_wd   = cnt_dec;
          ex_cnt  = cnt_dec;
          ex_push = (cnt_dec == '0) && !depth_full;
        end
      end
      OP_INCREF: begin
        if (!addr_ok_r) begin
          ex_sts = STS_BAD_ADDR;
        end else if (cnt_q == '0) begin
          ex_sts = STS_BAD_COUNT;
        end else if (cnt_q == {COUNT_BITS{1'b1}}) begin
          ex_sts = STS_SATURATED;
          ex_cnt = cnt_q;
        end else begin
          ex_we  = 1'b1;
          ex_wd  = cnt_inc;
          ex_cnt = cnt_inc;
        end
      end
      default: ex_sts = STS_OK;
    endcase
  end

  // memory write ports
  always_comb begin
    cnt_we = 1'b0;
    cnt_wa = ex_wa;
    cnt_wd = ex_wd;
    stk_we = 1'b0;
    stk_wd = page_r;
    if (cmd.sweep) begin
      cnt_we = 1'b1;
      cnt_wa = swp_r;
      cnt_wd = '0;
      stk_we = cmd.sweep_push && swp_in_rng;
      stk_wd = swp_r;
    end else if (cmd.exec) begin
      cnt_we = ex_we;
      stk_we = ex_push;
    end
  end

  always_comb begin
    depth_nxt = depth_r;
    if (cmd.depth_clr) begin
      depth_nxt = '0;
    end else if (stk_we) begin
      depth_nxt = depth_r + DEPTH_W'(1);
    end else if (cmd.exec && ex_pop) begin
      depth_nxt = depth_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
    if (cmd.cnt_rd) cnt_q <= cnt_mem[cnt_ra];
  end

  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[depth_r[PAGE_W-1:0]] <= stk_wd;
    if (cmd.stk_rd) stk_q <= stk_mem[stk_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r     <= FIRST_PAGE_RST;
      limit_r     <= LIMIT_PAGE_RST;
      depth_r     <= '0;
      swp_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_FIRST_PAGE) first_r <= cfg_data;
        if (cfg_index == CFG_LIMIT_PAGE) limit_r <= cfg_data;
      end
      depth_r <= depth_nxt;
      if (cmd.sweep) begin
        swp_r <= sts.sweep_last ? '0 : swp_r + PAGE_W'(1);
      end
      if (cmd.exec) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // beat capture and result register
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op_r      <= op_t'(in_opcode);
      addr_ok_r <= in_addr_ok;
      page_r    <= PAGE_W'(in_pfld);
    end
    if (cmd.exec) begin
      out_data_r <= {{PAD_W{1'b0}}, CNT_OUT_W'(ex_cnt), ex_addr, ex_sts};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DEPTH_W'(NUM_PAGES))
    else $error("free stack depth above page count");

  a_exec_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> !(out_valid_r && !out_tready))
    else $error("result written over a stalled beat");

  a_alloc_pops: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && op_r == OP_ALLOC && ex_sts == STS_OK) |=> depth_r == $past(depth_m1))
    else $error("successful alloc did not pop the stack");

  a_sweep_no_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sweep |-> !cmd.exec && !cmd.take)
    else $error("sweep overlaps another operation");

endmodule

@@ rtl/core/refcounted_page_allocator_core.sv @@
// Refcounted page allocator: LIFO free stack of page numbers plus a reference
// count per page. One request beat in, one result beat out.
//   in_tdata  : opcode [1:0], page_address [25:2]
//   out_tdata : status [2:0], result_address [26:3], count_after [34:27]
//   cfg port  : index 0 first_page, index 1 limit_page, taken on cfg_we
// Free and incref do a registered read-modify-write of the count memory; alloc
// first does a registered read of the free stack, then the same; init instead
// sweeps over the count memory, one page per cycle. One request is in flight at
// a time and in_tready returns once the result is written.
// After reset the count memory is cleared by a sweep over every page with
// in_tready low; config writes are taken throughout.
// The result sits in an output register: a new request is accepted while it
// waits, and that request holds in its last step until out_tready frees it.
// Depends on rpa_pkg, rpa_ctrl, rpa_datapath.
`timescale 1ns / 1ps

module refcounted_page_allocator_core
  import rpa_pkg::*;
#(
  parameter int NUM_PAGES  = NUM_PAGES_DEF,
  parameter int PAGE_SHIFT = PAGE_SHIFT_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // opcode, page_address
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // status, result_address, count_after
);

  dp_cmd_t          cmd;
  dp_sts_t          sts;
  logic [OPC_W-1:0] in_opcode;
  logic [ADDR_W-1:0] in_page_address;

  assign in_opcode       = in_tdata[OPC_W-1:0];
  assign in_page_address = in_tdata[OPC_W+ADDR_W-1:OPC_W];

  rpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_opcode (in_opcode),
    .cmd       (cmd),
    .sts       (sts)
  );

  rpa_datapath #(
    .NUM_PAGES  (NUM_PAGES),
    .PAGE_SHIFT (PAGE_SHIFT),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_opcode       (in_opcode),
    .in_page_address (in_page_address),
    .out_tready      (out_tready),
    .out_tvalid      (out_tvalid),
    .out_tdata       (out_tdata)
  );

endmodule

@@ tb/sv/tb_refcounted_page_allocator_core.sv @@
`timescale 1ns / 1ps
// self-checking testbench for refcounted_page_allocator_core: directed and random page
// requests with idle gaps on both streams, each result beat compared against a local model
// depends on rpa_pkg and the allocator RTL
module tb_refcounted_page_allocator_core;
  import rpa_pkg::*;

  localparam int NPAGES     = NUM_PAGES_DEF;
  localparam int PG_SHIFT   = PAGE_SHIFT_DEF;
  localparam int CNT_MAX    = (1 << COUNT_BITS_DEF) - 1;
  localparam int MAX_GAP    = 12;
  localparam int RAND_ITEMS = 1800;

  typedef enum logic [1:0] {REQ_RAW, REQ_LIVE, REQ_NEWEST, REQ_CFG} req_kind_t;

  typedef struct {
    req_kind_t            kind;
    op_t                  op;
    logic [ADDR_W-1:0]    addr;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_val;
  } page_req_t;

  typedef struct packed {
    sts_t                 status;
    logic [ADDR_W-1:0]    addr;
    logic [CNT_OUT_W-1:0] count;
  } page_reply_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [CFG_W-1:0]       cfg_data   = '0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // local copy of the allocator state
  bit [COUNT_BITS_DEF-1:0] page_refs [NPAGES];
  int                      free_pages [NPAGES];
  int                      free_top = 0;
  int                      first_pg = FIRST_PAGE_RST;
  int                      limit_pg = LIMIT_PAGE_RST;
  int                      held_pages[$];

  page_req_t   request_q[$];
  page_reply_t replies_due[$];
  int          err_cnt      = 0;
  int          send_gap     = 0;
  int          send_quiet   = 0;
  int          recv_gap     = 0;
  int          recv_quiet   = 0;
  int          hold_off     = 0;
  int          replies_seen = 0;

  refcounted_page_allocator_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void push_free(int pg);
    if (free_top < NPAGES) begin
      free_pages[free_top] = pg;
      free_top++;
    end
  endfunction

  function automatic page_reply_t compute_reply(op_t op, logic [ADDR_W-1:0] addr);
    page_reply_t r;
    int          pg;
    int          hi;
    bit          addr_ok;
    r.status = STS_OK;
    r.addr   = '0;
    r.count  = '0;
    pg       = int'(addr >> PG_SHIFT);
    addr_ok  = (addr[PG_SHIFT-1:0] == '0) && pg >= first_pg && pg < limit_pg && pg < NPAGES;
    case (op)
      OP_INIT: begin
        foreach (page_refs[i]) page_refs[i] = '0;
        free_top = 0;
        held_pages.delete();
        hi = (limit_pg < NPAGES) ? limit_pg : NPAGES;
        for (int p = first_pg; p < hi; p++) push_free(p);
      end
      OP_ALLOC: begin
        if (free_top == 0) begin
          r.status = STS_EMPTY;
        end else begin
          pg = free_pages[free_top-1];
          if (page_refs[pg] != 0) begin
            r.status = STS_BAD_COUNT;
            r.count  = page_refs[pg];
          end else begin
            free_top--;
            page_refs[pg] = COUNT_BITS_DEF'(1);
            r.addr  = ADDR_W'(pg << PG_SHIFT);
            r.count = CNT_OUT_W'(1);
            held_pages.push_back(pg);
          end
        end
      end
      OP_FREE: begin
        if (!addr_ok) begin
          r.status = STS_BAD_ADDR;
        end else if (page_refs[pg] == 0) begin
          r.status = STS_BAD_COUNT;
        end else begin
          page_refs[pg]--;
          if (page_refs[pg] == 0) begin
            push_free(pg);
            for (int i = 0; i < held_pages.size(); i++) begin
              if (held_pages[i] == pg) begin
                held_pages.delete(i);
                break;
              end
            end
          end
          r.count = page_refs[pg];
        end
      end
      default: begin
        if (!addr_ok) begin
          r.status = STS_BAD_ADDR;
        end else if (page_refs[pg] == 0) begin
          r.status = STS_BAD_COUNT;
        end else if (page_refs[pg] >= CNT_MAX) begin
          r.status = STS_SATURATED;
          r.count  = page_refs[pg];
        end else begin
          page_refs[pg]++;
          r.count = page_refs[pg];
        end
      end
    endcase
    return r;
  endfunction

  // idle cycles before the next beat, with occasional stretches of none
  function automatic int draw_gap(inout int quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) quiet = $urandom_range(8, 40);
    return $urandom_range(0, MAX_GAP);
  endfunction

  function automatic logic [ADDR_W-1:0] rand_page_addr();
    return ADDR_W'($urandom_range(0, NPAGES - 1) << PG_SHIFT);
  endfunction

  task automatic add_req(req_kind_t kind, op_t op, logic [ADDR_W-1:0] addr);
    page_req_t q;
    q.kind    = kind;
    q.op      = op;
    q.addr    = addr;
    q.cfg_idx = '0;
    q.cfg_val = '0;
    request_q.push_back(q);
  endtask

  task automatic add_cfg(logic [CFG_IDX_W-1:0] idx, int val);
    page_req_t q;
    q.kind    = REQ_CFG;
    q.op      = OP_INIT;
    q.addr    = '0;
    q.cfg_idx = idx;
    q.cfg_val = CFG_W'(val);
    request_q.push_back(q);
  endtask

  always @(posedge clk) begin : drive_requests
    page_req_t             nreq;
    logic                  nvalid;
    logic [IN_TDATA_W-1:0] ndata;
    logic                  nwe;
    logic [CFG_IDX_W-1:0]  nidx;
    logic [CFG_W-1:0]      nval;
    logic [ADDR_W-1:0]     a;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      cfg_we    <= 1'b0;
      cfg_index <= '0;
      cfg_data  <= '0;
    end else begin
      nvalid = in_tvalid;
      ndata  = in_tdata;
      nwe    = 1'b0;
      nidx   = cfg_index;
      nval   = cfg_data;
      if (in_tvalid && in_tready) begin
        replies_due.push_back(compute_reply(op_t'(in_tdata[OPC_W-1:0]),
                                            in_tdata[OPC_W +: ADDR_W]));
        nvalid   = 1'b0;
        send_gap = draw_gap(send_quiet);
      end
      if (!nvalid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (request_q.size() > 0) begin
          nreq = request_q[0];
          if (nreq.kind == REQ_CFG) begin
            // registers change only with nothing in flight
            if (replies_due.size() == 0) begin
              nwe  = 1'b1;
              nidx = nreq.cfg_idx;
              nval = nreq.cfg_val;
              if (nreq.cfg_idx == CFG_FIRST_PAGE) first_pg = nreq.cfg_val;
              else limit_pg = nreq.cfg_val;
              void'(request_q.pop_front());
            end
          end else begin
            a = nreq.addr;
            if (nreq.kind == REQ_NEWEST && held_pages.size() > 0)
              a = ADDR_W'(held_pages[$] << PG_SHIFT);
            else if (nreq.kind == REQ_LIVE && held_pages.size() > 0)
              a = ADDR_W'(held_pages[$urandom_range(0, held_pages.size() - 1)] << PG_SHIFT);
            ndata  = IN_TDATA_W'({a, nreq.op});
            nvalid = 1'b1;
            void'(request_q.pop_front());
          end
        end
      end
      in_tvalid <= nvalid;
      in_tdata  <= ndata;
      cfg_we    <= nwe;
      cfg_index <= nidx;
      cfg_data  <= nval;
    end
  end

  always @(posedge clk) begin : check_replies
    page_reply_t want;
    page_reply_t got;
    logic        nready;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      nready = out_tready;
      if (out_tvalid && out_tready) begin
        got.status = sts_t'(out_tdata[STS_W-1:0]);
        got.addr   = out_tdata[STS_W +: ADDR_W];
        got.count  = out_tdata[STS_W+ADDR_W +: CNT_OUT_W];
        if (replies_due.size() == 0) begin
          $error("result beat with nothing expected: %h", out_tdata);
          err_cnt++;
        end else begin
          want = replies_due.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            err_cnt++;
          end
          if (got.addr !== want.addr) begin
            $error("result_address: expected %h, got %h", want.addr, got.addr);
            err_cnt++;
          end
          if (got.count !== want.count) begin
            $error("count_after: expected %0d, got %0d", want.count, got.count);
            err_cnt++;
          end
        end
        replies_seen++;
        // long back-pressure so the block fills and stalls its input
        if (replies_seen == 150 || replies_seen == 900) hold_off = 300;
        nready   = 1'b0;
        recv_gap = draw_gap(recv_quiet);
      end
      if (hold_off > 0) begin
        hold_off--;
        nready = 1'b0;
      end else if (!nready) begin
        if (recv_gap > 0) recv_gap--;
        else nready = 1'b1;
      end
      out_tready <= nready;
    end
  end

  initial begin : stimulus
    int made;
    int n;
    int r;
    int phase;
    int lo;
    int hi;

    // directed part, reset config covers every page
    add_req(REQ_RAW, OP_ALLOC, '0);
    add_req(REQ_RAW, OP_FREE, 24'h000000);
    add_req(REQ_RAW, OP_INCREF, 24'h000001);
    add_req(REQ_RAW, OP_INIT, 24'hFFFFFF);
    add_req(REQ_RAW, OP_ALLOC, 24'hFFFFFF);
    add_req(REQ_RAW, OP_INCREF, 24'hFFF000);
    add_req(REQ_RAW, OP_INCREF, 24'hFFFFFF);
    repeat (3) add_req(REQ_RAW, OP_FREE, 24'hFFF000);
    add_req(REQ_RAW, OP_ALLOC, '0);
    add_req(REQ_RAW, OP_INCREF, 24'h001000);
    add_cfg(CFG_FIRST_PAGE, 16);
    add_cfg(CFG_LIMIT_PAGE, 20);
    add_req(REQ_RAW, OP_FREE, 24'hFFF000);
    add_req(REQ_RAW, OP_INIT, '0);
    add_req(REQ_RAW, OP_FREE, 24'h00F000);
    add_req(REQ_RAW, OP_INCREF, 24'h014000);
    repeat (5) add_req(REQ_RAW, OP_ALLOC, '0);
    add_req(REQ_RAW, OP_FREE, 24'h010000);
    add_cfg(CFG_FIRST_PAGE, 9);
    add_cfg(CFG_LIMIT_PAGE, 4);
    add_req(REQ_RAW, OP_INIT, '0);
    add_req(REQ_RAW, OP_ALLOC, '0);
    add_cfg(CFG_FIRST_PAGE, LIMIT_PAGE_RST);
    add_cfg(CFG_LIMIT_PAGE, LIMIT_PAGE_RST);
    add_req(REQ_RAW, OP_INIT, '0);
    add_req(REQ_RAW, OP_ALLOC, '0);

    made  = 0;
    phase = 0;
    while (made < RAND_ITEMS) begin
      if (phase == 2) begin
        // drive one page up to saturation and back down to free
        add_cfg(CFG_FIRST_PAGE, FIRST_PAGE_RST);
        add_cfg(CFG_LIMIT_PAGE, LIMIT_PAGE_RST);
        add_req(REQ_RAW, OP_INIT, '0);
        add_req(REQ_RAW, OP_ALLOC, '0);
        repeat (CNT_MAX + 1) add_req(REQ_NEWEST, OP_INCREF, rand_page_addr());
        repeat (CNT_MAX) add_req(REQ_NEWEST, OP_FREE, rand_page_addr());
        made += 2 * CNT_MAX + 3;
      end else begin
        r = $urandom_range(0, 9);
        if (r == 0) begin
          lo = FIRST_PAGE_RST;
          hi = LIMIT_PAGE_RST;
        end else if (r == 1) begin
          lo = $urandom_range(1, NPAGES);
          hi = $urandom_range(0, lo);
        end else begin
          lo = $urandom_range(0, NPAGES - 1);
          hi = lo + $urandom_range(0, 48);
          if (hi > NPAGES) hi = NPAGES;
        end
        case ($urandom_range(0, 3))
          0: begin
            add_cfg(CFG_FIRST_PAGE, lo);
            add_cfg(CFG_LIMIT_PAGE, hi);
          end
          1: add_cfg(CFG_FIRST_PAGE, lo);
          2: add_cfg(CFG_LIMIT_PAGE, hi);
          default: ;
        endcase
        if (phase == 0 || $urandom_range(0, 3) != 0) begin
          add_req(REQ_RAW, OP_INIT, ADDR_W'($urandom));
          made++;
        end
        n = $urandom_range(20, 90);
        repeat (n) begin
          r = $urandom_range(0, 99);
          if (r < 30) add_req(REQ_RAW, OP_ALLOC, ADDR_W'($urandom));
          else if (r < 55) add_req(REQ_LIVE, OP_FREE, rand_page_addr());
          else if (r < 75) add_req(REQ_LIVE, OP_INCREF, rand_page_addr());
          else if (r < 88) add_req(REQ_RAW, op_t'($urandom_range(1, 3)), ADDR_W'($urandom));
          else add_req(REQ_RAW, op_t'($urandom_range(2, 3)), rand_page_addr());
        end
        made += n;
      end
      phase++;
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    @(negedge clk);
    while (request_q.size() != 0 || in_tvalid) @(negedge clk);
    while (replies_due.size() != 0) @(negedge clk);
    repeat (16) @(posedge clk);
    if (err_cnt == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/rpa_pkg.sv
rtl/core/rpa_ctrl.sv
rtl/core/rpa_datapath.sv
rtl/core/refcounted_page_allocator_core.sv
tb/sv/tb_refcounted_page_allocator_core.sv
